@@ hdl/pvcl_pkg.sv @@
`default_nettype none
package pvcl_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_PEEP     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF_PHASE    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LAST_PHASE      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_DELAY_MS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_CLOSURE = 3'd4;

	localparam logic [7:0]  TARGET_PEEP_RST     = 8'd5;
	localparam logic [5:0]  CUTOFF_PHASE_RST    = 6'd0;
	localparam logic [5:0]  LAST_PHASE_RST      = 6'd20;
	localparam logic [15:0] SETTLE_DELAY_MS_RST = 16'd500;
	localparam logic [15:0] INITIAL_CLOSURE_RST = 16'd10;

	localparam logic [9:0]  DRIVE_OFFSET    = 10'd5;
	localparam logic [7:0]  JUMP_MIN_CHECKS = 8'd8;
	localparam logic [16:0] RECIP_THIRD     = 17'd43691;

	typedef struct packed {
		logic [7:0]  target_peep;
		logic [5:0]  cutoff_phase;
		logic [5:0]  last_phase;
		logic [15:0] settle_delay_ms;
		logic [15:0] initial_closure;
		logic        load_closure;
	} cfg_t;

	typedef struct packed {
		logic [9:0]  pressure;
		logic [5:0]  phase;
		logic [31:0] now_ms;
		logic        valve_held_closed;
		logic [31:0] closed_at_ms;
		logic        new_breath;
	} tick_t;

	typedef struct packed {
		logic [9:0]  valve_drive;
		logic [15:0] closure_cycle;
		logic [15:0] wasted_loops;
		logic        peep_checked;
	} result_t;

endpackage
`default_nettype wire

@@ hdl/pvcl_cfg.sv @@
`default_nettype none
module pvcl_cfg
	import pvcl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                        cfg
);

	logic [7:0]  target_peep_q;
	logic [5:0]  cutoff_phase_q;
	logic [5:0]  last_phase_q;
	logic [15:0] settle_delay_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_peep_q     <= TARGET_PEEP_RST;
			cutoff_phase_q    <= CUTOFF_PHASE_RST;
			last_phase_q      <= LAST_PHASE_RST;
			settle_delay_ms_q <= SETTLE_DELAY_MS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TARGET_PEEP:     target_peep_q     <= cfg_data[7:0];
				REG_CUTOFF_PHASE:    cutoff_phase_q    <= cfg_data[5:0];
				REG_LAST_PHASE:      last_phase_q      <= cfg_data[5:0];
				REG_SETTLE_DELAY_MS: settle_delay_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.target_peep     = target_peep_q;
		cfg.cutoff_phase    = cutoff_phase_q;
		cfg.last_phase      = last_phase_q;
		cfg.settle_delay_ms = settle_delay_ms_q;
		cfg.initial_closure = cfg_data;
		cfg.load_closure    = cfg_write && (cfg_index == REG_INITIAL_CLOSURE);
	end

endmodule
`default_nettype wire

@@ hdl/pvcl_core.sv @@
`default_nettype none
module pvcl_core
	import pvcl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  step,
	input  wire tick_t tick,
	output result_t    res
);

	logic [15:0] loop_count_q;
	logic [15:0] closure_cycle_q;
	logic [7:0]  checks_q;
	logic [15:0] wasted_q;
	logic        checked_q;

	logic [15:0] lc;
	logic        chk;
	logic        below;
	logic        close_now;
	logic [9:0]  tgt;
	logic [9:0]  half;
	logic [9:0]  three_half;
	logic [9:0]  tgt3;
	logic        p_low;
	logic        p_under;
	logic        p_high;
	logic        p_over;
	logic [15:0] wasted_n;
	logic [15:0] lc_n;
	logic [31:0] deadline;
	logic        do_check;
	logic [7:0]  checks_inc;
	logic        big_drop;
	logic [33:0] third_prod;
	logic [16:0] dbl;
	logic [15:0] c1;
	logic [17:0] tri3;
	logic [16:0] grow;
	logic [15:0] c2;
	logic [15:0] cc_n;
	logic [7:0]  checks_n;
	logic        checked_n;

	always_comb begin
		lc    = tick.new_breath ? 16'd0 : loop_count_q;
		chk   = tick.new_breath ? 1'b0 : checked_q;
		below = lc < closure_cycle_q;
		close_now = !below || (tick.phase == cfg.last_phase);

		tgt        = {2'b00, cfg.target_peep};
		half       = {3'b000, cfg.target_peep[7:1]};
		tgt3       = tgt + {1'b0, cfg.target_peep, 1'b0};
		three_half = {1'b0, tgt3[9:1]};
		p_low   = tick.pressure < half;
		p_under = tick.pressure < tgt;
		p_high  = tick.pressure > three_half;
		p_over  = tick.pressure > tgt;

		res.valve_drive = close_now ? (tgt - DRIVE_OFFSET) : (tgt + DRIVE_OFFSET);

		wasted_n = wasted_q;
		if (below && p_low && (wasted_q != 16'hFFFF)) begin
			wasted_n = wasted_q + 16'd1;
		end
		lc_n = (lc == 16'hFFFF) ? lc : lc + 16'd1;

		deadline = tick.closed_at_ms + {16'd0, cfg.settle_delay_ms};
		do_check = !chk && ((tick.valve_held_closed && (tick.phase > cfg.cutoff_phase) &&
			(tick.now_ms > deadline)) || (tick.phase == cfg.last_phase));

		checks_inc = (checks_q == 8'hFF) ? checks_q : checks_q + 8'd1;
		big_drop   = p_low && (checks_inc > JUMP_MIN_CHECKS);

		dbl        = {closure_cycle_q, 1'b0};
		third_prod = {17'd0, dbl} * {17'd0, RECIP_THIRD};

		checks_n = checks_inc;
		if (big_drop) begin
			c1       = third_prod[32:17];
			checks_n = 8'd0;
		end else if (p_under) begin
			c1 = (closure_cycle_q > 16'd2) ? closure_cycle_q - 16'd1 : 16'd1;
		end else begin
			c1 = closure_cycle_q;
		end

		tri3 = {2'b00, c1} + {1'b0, c1, 1'b0};
		grow = tri3[17:1];
		if (p_high) begin
			c2       = (grow > 17'h0FFFF) ? 16'hFFFF : grow[15:0];
			checks_n = 8'd0;
		end else if (p_over) begin
			c2 = (c1 == 16'hFFFF) ? c1 : c1 + 16'd1;
		end else begin
			c2 = c1;
		end

		cc_n      = do_check ? c2 : closure_cycle_q;
		checked_n = do_check ? 1'b1 : chk;

		res.closure_cycle = cc_n;
		res.wasted_loops  = wasted_n;
		res.peep_checked  = checked_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_count_q    <= 16'd0;
			closure_cycle_q <= INITIAL_CLOSURE_RST;
			checks_q        <= 8'd0;
			wasted_q        <= 16'd0;
			checked_q       <= 1'b0;
		end else if (cfg.load_closure) begin
			closure_cycle_q <= cfg.initial_closure;
		end else if (step) begin
			loop_count_q    <= lc_n;
			closure_cycle_q <= cc_n;
			wasted_q        <= wasted_n;
			checked_q       <= checked_n;
			if (do_check) begin
				checks_q <= checks_n;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/peep_valve_closure_learner_unit.sv @@
`default_nettype none
// One control tick is taken per clock cycle while the output is not stalled, and its valve drive is
// presented from the output register: the tick is captured in an input register, the learner state
// is read and updated in combinational logic, and the result lands in the output register, so ticks
// may follow each other in every cycle while the output is not stalled.
// Writing the initial closure register also reloads the learned closure cycle at once.
module peep_valve_closure_learner_unit
	import pvcl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   tick_valid,
	output logic                        tick_stall,
	input  wire logic [9:0]             pressure,
	input  wire logic [5:0]             phase,
	input  wire logic [31:0]            now_ms,
	input  wire logic                   valve_held_closed,
	input  wire logic [31:0]            closed_at_ms,
	input  wire logic                   new_breath,
	output logic                        drive_valid,
	input  wire logic                   drive_stall,
	output logic signed [9:0]           valve_drive,
	output logic [15:0]                 closure_cycle_out,
	output logic [15:0]                 wasted_loops_out,
	output logic                        peep_checked
);

	cfg_t    cfg;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	assign advance    = valid_s1 && (!valid_s2 || !drive_stall);
	assign tick_stall = valid_s1 && !advance;

	pvcl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pvcl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.tick   (tick_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!tick_stall) begin
				valid_s1 <= tick_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!drive_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1.pressure          <= pressure;
			tick_s1.phase             <= phase;
			tick_s1.now_ms            <= now_ms;
			tick_s1.valve_held_closed <= valve_held_closed;
			tick_s1.closed_at_ms      <= closed_at_ms;
			tick_s1.new_breath        <= new_breath;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign drive_valid       = valid_s2;
	assign valve_drive       = res_s2.valve_drive;
	assign closure_cycle_out = res_s2.closure_cycle;
	assign wasted_loops_out  = res_s2.wasted_loops;
	assign peep_checked      = res_s2.peep_checked;

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none

module testbench
	import pvcl_pkg::*;
();

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   tick_valid;
	logic                   tick_stall;
	logic [9:0]             pressure;
	logic [5:0]             phase;
	logic [31:0]            now_ms;
	logic                   valve_held_closed;
	logic [31:0]            closed_at_ms;
	logic                   new_breath;
	logic                   drive_valid;
	logic                   drive_stall = 1'b0;
	logic signed [9:0]      valve_drive;
	logic [15:0]            closure_cycle_out;
	logic [15:0]            wasted_loops_out;
	logic                   peep_checked;

	peep_valve_closure_learner_unit u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.tick_valid        (tick_valid),
		.tick_stall        (tick_stall),
		.pressure          (pressure),
		.phase             (phase),
		.now_ms            (now_ms),
		.valve_held_closed (valve_held_closed),
		.closed_at_ms      (closed_at_ms),
		.new_breath        (new_breath),
		.drive_valid       (drive_valid),
		.drive_stall       (drive_stall),
		.valve_drive       (valve_drive),
		.closure_cycle_out (closure_cycle_out),
		.wasted_loops_out  (wasted_loops_out),
		.peep_checked      (peep_checked)
	);

	// Learner state and register copies kept by the testbench.
	logic [7:0]  peep_target;
	logic [5:0]  cut_phase;
	logic [5:0]  end_phase;
	logic [15:0] settle_ms;
	logic [15:0] loops;
	logic [15:0] cycle;
	logic [7:0]  jump_checks;
	logic [15:0] wasted;
	logic        checked;

	result_t drive_q[$];
	int      mismatches = 0;
	int      cycle_count = 0;
	int      stall_left = 0;
	bit      quiet = 1'b0;
	logic    hold_on = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left--;
		else if (!quiet && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 15);
		drive_stall <= hold_on || (stall_left != 0);
	end

	function automatic result_t learn_tick(input tick_t t);
		result_t     r;
		logic [31:0] deadline;
		int unsigned p;
		int unsigned tt;
		int unsigned c;
		p = t.pressure;
		tt = peep_target;
		if (t.new_breath) begin
			loops = '0;
			checked = 1'b0;
		end
		if (loops < cycle && p < tt / 2 && wasted != 16'hFFFF)
			wasted++;
		if (loops < cycle && t.phase != end_phase)
			r.valve_drive = {2'b00, peep_target} + 10'd5;
		else
			r.valve_drive = {2'b00, peep_target} - 10'd5;
		if (loops != 16'hFFFF)
			loops++;
		deadline = t.closed_at_ms + {16'h0000, settle_ms};
		if (!checked && ((t.valve_held_closed && t.phase > cut_phase && t.now_ms > deadline)
				|| t.phase == end_phase)) begin
			c = cycle;
			if (jump_checks != 8'hFF)
				jump_checks++;
			if (p < tt / 2 && jump_checks > 8) begin
				c = c * 2 / 3;
				jump_checks = '0;
			end else if (p < tt) begin
				c = (c > 2) ? c - 1 : 1;
			end
			if (p > tt * 3 / 2) begin
				c = c * 3 / 2;
				jump_checks = '0;
			end else if (p > tt) begin
				c = c + 1;
			end
			cycle = (c > 16'hFFFF) ? 16'hFFFF : c[15:0];
			checked = 1'b1;
		end
		r.closure_cycle = cycle;
		r.wasted_loops = wasted;
		r.peep_checked = checked;
		return r;
	endfunction

	task automatic check_field(input string name, input int expected, input int actual);
		if (expected != actual) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, expected, actual);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && drive_valid && !drive_stall) begin
			if (drive_q.size() == 0) begin
				$display("%0t: valve_drive expected none, actual %0d", $time, valve_drive);
				mismatches++;
			end else begin
				exp_r = drive_q.pop_front();
				check_field("valve_drive", $signed(exp_r.valve_drive), valve_drive);
				check_field("closure_cycle_out", exp_r.closure_cycle, closure_cycle_out);
				check_field("wasted_loops_out", exp_r.wasted_loops, wasted_loops_out);
				check_field("peep_checked", exp_r.peep_checked, peep_checked);
			end
		end
	end

	function automatic tick_t make_tick(input logic [9:0] p, input logic [5:0] ph,
			input logic [31:0] now, input logic held, input logic [31:0] closed,
			input logic nb);
		tick_t t;
		t.pressure = p;
		t.phase = ph;
		t.now_ms = now;
		t.valve_held_closed = held;
		t.closed_at_ms = closed;
		t.new_breath = nb;
		return t;
	endfunction

	function automatic logic [9:0] pick_pressure();
		int unsigned tt;
		int unsigned v;
		tt = peep_target;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, tt / 2);
			1: v = $urandom_range(tt / 2, tt);
			2: v = tt;
			3: v = $urandom_range(tt, tt * 3 / 2);
			4: v = $urandom_range(tt * 3 / 2, tt * 2 + 2);
			default: v = $urandom_range(0, 1023);
		endcase
		return v[9:0];
	endfunction

	task automatic send_tick(input tick_t t);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		tick_valid <= 1'b1;
		pressure <= t.pressure;
		phase <= t.phase;
		now_ms <= t.now_ms;
		valve_held_closed <= t.valve_held_closed;
		closed_at_ms <= t.closed_at_ms;
		new_breath <= t.new_breath;
		do
			@(posedge clk);
		while (tick_stall);
		drive_q.push_back(learn_tick(t));
	endtask

	// Registers change only once every outstanding transfer has come out of the block.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
		logic [15:0] bus;
		bus = 16'($urandom);
		tick_valid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		case (idx)
			REG_TARGET_PEEP: begin
				bus[7:0] = value[7:0];
				peep_target = value[7:0];
			end
			REG_CUTOFF_PHASE: begin
				bus[5:0] = value[5:0];
				cut_phase = value[5:0];
			end
			REG_LAST_PHASE: begin
				bus[5:0] = value[5:0];
				end_phase = value[5:0];
			end
			REG_SETTLE_DELAY_MS: begin
				bus = value;
				settle_ms = value;
			end
			REG_INITIAL_CLOSURE: begin
				bus = value;
				cycle = value;
			end
			default: ;
		endcase
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= bus;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic test_default_breath();
		send_tick(make_tick(10'd0, 6'd1, 32'd0, 1'b0, 32'd0, 1'b1));
		send_tick(make_tick(10'd1023, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0));
		send_tick(make_tick(10'd1, 6'd20, 32'd0, 1'b0, 32'd0, 1'b1));
		send_tick(make_tick(10'd6, 6'd5, 32'h0000_0100, 1'b1, 32'hFFFF_FF00, 1'b1));
		send_tick(make_tick(10'd5, 6'd5, 32'd1500, 1'b1, 32'd1000, 1'b1));
		send_tick(make_tick(10'd5, 6'd5, 32'd1501, 1'b1, 32'd1000, 1'b0));
		send_tick(make_tick(10'd9, 6'd0, 32'hFFFF_0000, 1'b1, 32'd0, 1'b1));
	endtask

	// Drives the cycle down to its floor, through zero, and back up again.
	task automatic test_learning_rules();
		write_reg(REG_TARGET_PEEP, 16'd20);
		write_reg(REG_CUTOFF_PHASE, 16'd3);
		write_reg(REG_LAST_PHASE, 16'd20);
		write_reg(REG_SETTLE_DELAY_MS, 16'd100);
		write_reg(REG_INITIAL_CLOSURE, 16'd2);
		for (int i = 0; i < 10; i++)
			send_tick(make_tick(10'd5, 6'd20, 32'd0, 1'b0, 32'd0, 1'b1));
		send_tick(make_tick(10'd0, 6'd4, 32'd0, 1'b0, 32'd0, 1'b1));
		send_tick(make_tick(10'd15, 6'd20, 32'd0, 1'b0, 32'd0, 1'b1));
		send_tick(make_tick(10'd40, 6'd20, 32'd0, 1'b0, 32'd0, 1'b1));
		send_tick(make_tick(10'd25, 6'd20, 32'd0, 1'b0, 32'd0, 1'b1));
		send_tick(make_tick(10'd25, 6'd20, 32'd0, 1'b0, 32'd0, 1'b1));
		send_tick(make_tick(10'd31, 6'd20, 32'd0, 1'b0, 32'd0, 1'b1));
		for (int i = 0; i < 6; i++)
			send_tick(make_tick(10'd3, 6'd4, 32'd1000 + 25 * i, 1'b1, 32'd1000, i == 0));
	endtask

	task automatic test_register_extremes();
		write_reg(REG_TARGET_PEEP, 16'd0);
		write_reg(REG_CUTOFF_PHASE, 16'd63);
		write_reg(REG_LAST_PHASE, 16'd0);
		write_reg(REG_SETTLE_DELAY_MS, 16'hFFFF);
		write_reg(REG_INITIAL_CLOSURE, 16'hFFFF);
		write_reg(3'd5, 16'd1);
		write_reg(3'd7, 16'd3);
		send_tick(make_tick(10'd0, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1));
		send_tick(make_tick(10'd1, 6'd0, 32'd0, 1'b0, 32'd0, 1'b0));
		send_tick(make_tick(10'd0, 6'd0, 32'd0, 1'b0, 32'd0, 1'b1));
		write_reg(REG_TARGET_PEEP, 16'd255);
		write_reg(REG_CUTOFF_PHASE, 16'd0);
		write_reg(REG_LAST_PHASE, 16'd63);
		write_reg(REG_SETTLE_DELAY_MS, 16'd0);
		write_reg(REG_INITIAL_CLOSURE, 16'd1);
		send_tick(make_tick(10'd100, 6'd1, 32'd1, 1'b1, 32'd0, 1'b1));
		send_tick(make_tick(10'd1023, 6'd63, 32'd0, 1'b0, 32'd0, 1'b1));
		send_tick(make_tick(10'd0, 6'd2, 32'd0, 1'b1, 32'd0, 1'b0));
	endtask

	task automatic test_counter_limits();
		quiet = 1'b1;
		write_reg(REG_TARGET_PEEP, 16'd255);
		write_reg(REG_CUTOFF_PHASE, 16'd63);
		write_reg(REG_LAST_PHASE, 16'd63);
		write_reg(REG_INITIAL_CLOSURE, 16'hFFFF);
		send_tick(make_tick(10'd0, 6'd1, 32'd0, 1'b0, 32'd0, 1'b1));
		for (int i = 0; i < 40; i++)
			send_tick(make_tick(10'd0, 6'd1, i, 1'b1, 32'd0, 1'b0));
		send_tick(make_tick(10'd1023, 6'd63, 32'd0, 1'b0, 32'd0, 1'b1));
		for (int i = 0; i < 260; i++)
			send_tick(make_tick(10'd255, 6'd63, 32'd0, 1'b0, 32'd0, 1'b1));
		send_tick(make_tick(10'd0, 6'd63, 32'd0, 1'b0, 32'd0, 1'b1));
		quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		write_reg(REG_TARGET_PEEP, 16'd30);
		write_reg(REG_LAST_PHASE, 16'd40);
		write_reg(REG_INITIAL_CLOSURE, 16'd12);
		fork
			begin
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
			begin
				for (int i = 0; i < 40; i++)
					send_tick(make_tick(pick_pressure(), 6'(i), 25 * i, i > 20, 32'd500,
						i == 0));
			end
		join
	endtask

	task automatic run_breath();
		int          n;
		int          close_at;
		logic [31:0] clock_ms;
		logic [31:0] shut_ms;
		logic [5:0]  ph;
		logic        held;
		n = $urandom_range(1, 24);
		close_at = $urandom_range(0, n);
		clock_ms = $urandom;
		shut_ms = $urandom;
		held = 1'b0;
		ph = 6'($urandom_range(0, 8));
		for (int i = 0; i < n; i++) begin
			if (i == close_at) begin
				held = 1'b1;
				shut_ms = clock_ms;
			end
			if (i == n - 1 && $urandom_range(0, 1) == 0)
				ph = end_phase;
			send_tick(make_tick(pick_pressure(), ph, clock_ms, held, shut_ms,
				i == 0 && $urandom_range(0, 7) != 0));
			clock_ms += 25;
			if ($urandom_range(0, 2) == 0 && ph != 6'd63)
				ph++;
		end
	endtask

	task automatic test_random();
		int sent;
		for (int k = 0; k < 5; k++) begin
			case (k)
				1: begin
					write_reg(REG_TARGET_PEEP, 16'd0);
					write_reg(REG_CUTOFF_PHASE, 16'd0);
					write_reg(REG_LAST_PHASE, 16'd0);
					write_reg(REG_SETTLE_DELAY_MS, 16'd0);
					write_reg(REG_INITIAL_CLOSURE, 16'd1);
				end
				2: begin
					write_reg(REG_TARGET_PEEP, 16'd255);
					write_reg(REG_CUTOFF_PHASE, 16'd63);
					write_reg(REG_LAST_PHASE, 16'd63);
					write_reg(REG_SETTLE_DELAY_MS, 16'hFFFF);
					write_reg(REG_INITIAL_CLOSURE, 16'hFFFF);
				end
				default: begin
					write_reg(REG_TARGET_PEEP, 16'($urandom_range(10, 60)));
					write_reg(REG_CUTOFF_PHASE, 16'($urandom_range(0, 5)));
					write_reg(REG_LAST_PHASE, 16'($urandom_range(10, 40)));
					write_reg(REG_SETTLE_DELAY_MS, 16'($urandom_range(0, 150)));
					write_reg(REG_INITIAL_CLOSURE, 16'($urandom_range(1, 20)));
				end
			endcase
			if (k == 4)
				quiet = 1'b1;
			sent = 0;
			while (sent < 120) begin
				if ($urandom_range(0, 4) == 0) begin
					send_tick(make_tick(10'($urandom_range(0, 1023)),
						6'($urandom_range(0, 63)), $urandom,
						1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 3) == 0));
					sent++;
				end else begin
					run_breath();
					sent += 12;
				end
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tick_valid = 1'b0;
		pressure = '0;
		phase = '0;
		now_ms = '0;
		valve_held_closed = 1'b0;
		closed_at_ms = '0;
		new_breath = 1'b0;
		peep_target = TARGET_PEEP_RST;
		cut_phase = CUTOFF_PHASE_RST;
		end_phase = LAST_PHASE_RST;
		settle_ms = SETTLE_DELAY_MS_RST;
		loops = '0;
		cycle = INITIAL_CLOSURE_RST;
		jump_checks = '0;
		wasted = '0;
		checked = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_breath();
		test_learning_rules();
		test_register_extremes();
		test_counter_limits();
		test_backpressure();
		test_random();

		tick_valid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
